// ===== rtl/lcg_mixed_random_generator_unit_assert.svh =====
// assertion macros for the mixed lcg random generator
// used by modules that have clk_i and rst_ni in scope
`ifndef LCG_MIXED_RANDOM_GENERATOR_UNIT_ASSERT_SVH
`define LCG_MIXED_RANDOM_GENERATOR_UNIT_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define LCGMIX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lcgmix assertion failed");

// condition that must never be seen outside reset
`define LCGMIX_NEVER(lbl, cond) \
  `LCGMIX_ASSERT(lbl, !(cond))

`endif

// ===== rtl/lcgmix_pkg.sv =====
// constants and types for the mixed lcg random generator
// no dependencies
package lcgmix_pkg;

  localparam logic [63:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] LCG_INCR = 64'h1405_7B7E_F767_814F;
  localparam logic [63:0] MIX_MULT = 64'hFF51_AFD7_ED55_8CCD;
  localparam int unsigned MIX_SHIFT = 33;
  localparam int unsigned FRAC_SHIFT = 11;
  localparam int unsigned FRAC_W = 53;
  localparam int unsigned INT_W = 31;

  typedef enum logic [1:0] {
    MODE_INT  = 2'd0,
    MODE_FRAC = 2'd1,
    MODE_SEED = 2'd2
  } mode_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/lcgmix_req_if.sv =====
// request channel of the mixed lcg random generator
// no dependencies
interface lcgmix_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] bound;
  logic [63:0]        seed_value;

  modport source (output valid, mode, bound, seed_value, input ready);
  modport sink (input valid, mode, bound, seed_value, output ready);
endinterface

// ===== rtl/lcgmix_rsp_if.sv =====
// response channel of the mixed lcg random generator
// no dependencies
interface lcgmix_rsp_if;
  logic        valid;
  logic        ready;
  logic [30:0] int_value;
  logic [52:0] fraction_value;

  modport source (output valid, int_value, fraction_value, input ready);
  modport sink (input valid, int_value, fraction_value, output ready);
endinterface

// ===== rtl/lcgmix_divider.sv =====
// radix-2 restoring remainder unit, one quotient bit per cycle
// depends on lcgmix_pkg
module lcgmix_divider import lcgmix_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [30:0] divisor_i,
  output logic [30:0] remainder_o,
  output div_sts_t    sts_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [30:0] rem_q;
  logic [31:0] dvd_q;
  logic [30:0] dsr_q;
  logic [31:0] shifted;
  logic [31:0] trial;

  assign shifted = {rem_q, dvd_q[31]};
  assign trial   = (shifted >= {1'b0, dsr_q}) ? shifted - {1'b0, dsr_q} : shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= trial[30:0];
        dvd_q <= {dvd_q[30:0], 1'b0};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign remainder_o = rem_q;
  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;

endmodule

// ===== rtl/lcg_mixed_random_generator_unit.sv =====
// mixed lcg random generator: 64-bit lcg step, multiply mix, integer or fraction result
// integer request: lcg multiply, mix multiply, then remainder unit; fraction request: lcg multiply only;
//   bound zero or negative: zero result without multiplying; seed load gives no transfer
// flow: one request at a time; the next is taken once the sequencer is idle again and no
//   response is pending or the pending one is being taken
// reset: generator state cleared to zero, sequencer idle, no response pending
module lcg_mixed_random_generator_unit import lcgmix_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  lcgmix_req_if.sink     req_i,
  lcgmix_rsp_if.source   rsp_o
);

  `include "lcg_mixed_random_generator_unit_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_POST,
    ST_DIV
  } state_e;

  state_e      state_q;
  logic [1:0]  step_q;
  logic        phase_mix_q;
  logic        frac_mode_q;
  logic [30:0] bound_q;
  logic [63:0] gen_state_q;
  logic [63:0] op_a_q;
  logic [63:0] acc_q;
  logic [63:0] prod_q;
  logic        out_valid_q;
  logic [30:0] int_q;
  logic [52:0] frac_q;

  logic        req_xfer;
  logic [63:0] mult_k;
  logic [31:0] a_sel;
  logic [31:0] b_sel;
  logic [63:0] prod_d;
  logic [63:0] lcg_x;
  logic [63:0] lcg_fx;
  logic [63:0] mix_y;
  logic        div_start;
  logic [30:0] div_rem;
  div_sts_t    div_sts;

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_xfer    = req_i.valid && req_i.ready;

  // shared 32x32 multiplier, low 64 bits of a 64x64 product over three passes
  assign mult_k = phase_mix_q ? MIX_MULT : LCG_MULT;
  always_comb begin
    case (step_q)
      2'd0: begin
        a_sel = op_a_q[31:0];
        b_sel = mult_k[31:0];
      end
      2'd1: begin
        a_sel = op_a_q[31:0];
        b_sel = mult_k[63:32];
      end
      default: begin
        a_sel = op_a_q[63:32];
        b_sel = mult_k[31:0];
      end
    endcase
  end
  assign prod_d = {32'd0, a_sel} * {32'd0, b_sel};

  assign lcg_x  = acc_q + LCG_INCR;
  assign lcg_fx = lcg_x ^ (lcg_x >> FRAC_SHIFT);
  assign mix_y  = acc_q ^ (acc_q >> MIX_SHIFT);

  assign div_start = (state_q == ST_POST) && phase_mix_q;

  lcgmix_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mix_y[63:32]),
    .divisor_i   (bound_q),
    .remainder_o (div_rem),
    .sts_o       (div_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      phase_mix_q <= 1'b0;
      frac_mode_q <= 1'b0;
      gen_state_q <= '0;
      out_valid_q <= 1'b0;
      bound_q     <= '0;
      op_a_q      <= '0;
      acc_q       <= '0;
      prod_q      <= '0;
      int_q       <= '0;
      frac_q      <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_xfer) begin
            case (req_i.mode)
              MODE_SEED: begin
                gen_state_q <= req_i.seed_value;
              end
              MODE_FRAC: begin
                frac_mode_q <= 1'b1;
                phase_mix_q <= 1'b0;
                op_a_q      <= gen_state_q;
                step_q      <= '0;
                state_q     <= ST_MUL;
              end
              MODE_INT: begin
                if (req_i.bound[31] || (req_i.bound == 32'sd0)) begin
                  int_q       <= '0;
                  frac_q      <= '0;
                  out_valid_q <= 1'b1;
                end else begin
                  frac_mode_q <= 1'b0;
                  phase_mix_q <= 1'b0;
                  bound_q     <= req_i.bound[30:0];
                  op_a_q      <= gen_state_q;
                  step_q      <= '0;
                  state_q     <= ST_MUL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MUL: begin
          prod_q <= prod_d;
          step_q <= step_q + 2'd1;
          case (step_q)
            2'd0: begin
            end
            2'd1: begin
              acc_q <= prod_q;
            end
            default: begin
              acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
            end
          endcase
          if (step_q == 2'd3) begin
            state_q <= ST_POST;
          end
        end
        ST_POST: begin
          if (!phase_mix_q) begin
            gen_state_q <= lcg_x;
            if (frac_mode_q) begin
              frac_q      <= lcg_fx[63:FRAC_SHIFT];
              int_q       <= '0;
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end else begin
              op_a_q      <= lcg_x ^ (lcg_x >> MIX_SHIFT);
              phase_mix_q <= 1'b1;
              step_q      <= '0;
              state_q     <= ST_MUL;
            end
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_sts.done) begin
            int_q       <= div_rem;
            frac_q      <= '0;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.int_value      = int_q;
  assign rsp_o.fraction_value = frac_q;

  `LCGMIX_NEVER(a_busy_no_rsp, out_valid_q && (state_q != ST_IDLE))
  `LCGMIX_NEVER(a_div_done_in_div, div_sts.done && (state_q != ST_DIV))
  `LCGMIX_NEVER(a_div_busy_in_div, div_sts.busy && (state_q != ST_DIV))
  `LCGMIX_ASSERT(a_state_hold, (!req_xfer && (state_q != ST_POST)) |=> $stable(gen_state_q))
  `LCGMIX_NEVER(a_one_field, out_valid_q && (int_q != 31'd0) && (frac_q != 53'd0))

endmodule
